// File: design/pffs_pkg.sv
// ----------------------------------------------------------------------------
// pffs_pkg: shared types and constants for the potential field force sum
// Request and register codes, the divider command and the overflow mark.
// ----------------------------------------------------------------------------
package pffs_pkg;

	// request kinds
	localparam logic [1:0] REQ_BEGIN = 2'd0;
	localparam logic [1:0] REQ_OBST  = 2'd1;
	localparam logic [1:0] REQ_QUARK = 2'd2;

	// register indexes
	localparam logic [2:0] REG_GOAL_X      = 3'd0;
	localparam logic [2:0] REG_GOAL_Y      = 3'd1;
	localparam logic [2:0] REG_ATT_GAIN    = 3'd2;
	localparam logic [2:0] REG_OBST_GAIN   = 3'd3;
	localparam logic [2:0] REG_OBST_RANGE  = 3'd4;
	localparam logic [2:0] REG_QUARK_GAIN  = 3'd5;
	localparam logic [2:0] REG_QUARK_RANGE = 3'd6;

	localparam int ADDR_W = 5;

	// magnitude that stands for an overflowed quotient (2^40)
	localparam logic [63:0] MAG_HUGE = 64'h0000_0100_0000_0000;

	typedef struct packed {
		logic start;
		logic scale;
	} div_cmd_t;

endpackage

// File: design/pffs_div.sv
// ----------------------------------------------------------------------------
// pffs_div: bit-serial unsigned divider
// Restoring division of a 64-bit numerator (optionally scaled up by the
// fraction bits) by a 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pffs_div import pffs_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  div_cmd_t    cmd,
	input  logic [63:0] numer,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quot
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] work_q;
	logic [31:0] rem_q;
	logic        ovf_q;
	logic [32:0] rem_sh;
	logic        ge;

	// trial subtract of the shifted remainder
	assign rem_sh = {rem_q, work_q[63]};
	assign ge     = rem_sh >= {1'b0, divisor};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: load, then shift one quotient bit in per cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			if (cmd.scale) begin
				work_q <= numer << FRAC_BITS;
				ovf_q  <= ((numer >> (63 - FRAC_BITS)) != 64'd0) || (numer >= MAG_HUGE);
			end else begin
				work_q <= numer;
				ovf_q  <= 1'b0;
			end
		end else if (busy_q) begin
			rem_q  <= ge ? 32'(rem_sh - {1'b0, divisor}) : rem_sh[31:0];
			work_q <= {work_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quot = (ovf_q || (work_q >= MAG_HUGE)) ? MAG_HUGE : work_q;

endmodule

// File: design/potential_field_force_sum_core.sv
// Begin item: goal difference, squares, sum, bit-serial square root and gain
// multiply, then three divides (a shift instead when the distance is at most one).
// Obstacle or quark reading in range: range check, gain multiply, two divides
// (none at zero distance); out of range: range check only; unused kind: no work.
// One item in flight at a time; a stalled result holds the block until it is taken.
// Reset clears the sums, the saturation flag and the output valid, and loads the
// register reset values (unit gains and ranges, goal at the origin).
// ----------------------------------------------------------------------------
// potential_field_force_sum_core: potential-field force accumulator
// Attractive term on begin, repulsive terms per reading, saturated Q16.16.
// ----------------------------------------------------------------------------
module potential_field_force_sum_core import pffs_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic [31:0]       pos_x,
	input  logic [31:0]       pos_y,
	input  logic [31:0]       reading_dist,
	input  logic [31:0]       dir_x,
	input  logic [31:0]       dir_y,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       force_x,
	output logic [31:0]       force_y,
	output logic              saturated
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIFF  = 4'd1;
	localparam logic [3:0] ST_SQ    = 4'd2;
	localparam logic [3:0] ST_SUM   = 4'd3;
	localparam logic [3:0] ST_SQRT  = 4'd4;
	localparam logic [3:0] ST_AMUL  = 4'd5;
	localparam logic [3:0] ST_SHIFT = 4'd6;
	localparam logic [3:0] ST_DIVGO = 4'd7;
	localparam logic [3:0] ST_DIVW  = 4'd8;
	localparam logic [3:0] ST_SIGN  = 4'd9;
	localparam logic [3:0] ST_REP   = 4'd10;
	localparam logic [3:0] ST_RMUL  = 4'd11;
	localparam logic [3:0] ST_FIN   = 4'd12;

	localparam logic [31:0] ONE_RAW = 32'(1) << FRAC_BITS;

	// configuration
	logic [31:0] goal_x_q, goal_y_q, att_gain_q, obst_gain_q, quark_gain_q;
	logic [30:0] obst_range_q, quark_range_q;

	// item and working state
	logic [3:0]  state_q;
	logic [1:0]  kind_q;
	logic [31:0] pos_x_q, pos_y_q, dist_q, dir_x_q, dir_y_q;
	logic        last_q;
	logic [31:0] dx_q, dy_q;
	logic        sat_acc_q;
	logic [63:0] val_x_q, val_y_q;
	logic        neg_x_q, neg_y_q;
	logic [63:0] sq_sh_q;
	logic [35:0] srem_q;
	logic [31:0] root_q;
	logic [4:0]  scnt_q;
	logic [31:0] divisor_q;
	logic [1:0]  div_left_q;
	logic        div_first_q;
	logic [31:0] sum_x_q, sum_y_q;
	logic        sat_seen_q;
	logic        out_valid_q;
	logic [31:0] force_x_q, force_y_q;
	logic        saturated_q;

	// configuration port
	logic [2:0] reg_idx;
	logic       cfg_wr;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q      <= '0;
			goal_y_q      <= '0;
			att_gain_q    <= 32'd65536;
			obst_gain_q   <= 32'd65536;
			obst_range_q  <= 31'd65536;
			quark_gain_q  <= 32'd65536;
			quark_range_q <= 31'd65536;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_GOAL_X:      goal_x_q      <= pwdata;
				REG_GOAL_Y:      goal_y_q      <= pwdata;
				REG_ATT_GAIN:    att_gain_q    <= pwdata;
				REG_OBST_GAIN:   obst_gain_q   <= pwdata;
				REG_OBST_RANGE:  obst_range_q  <= pwdata[30:0];
				REG_QUARK_GAIN:  quark_gain_q  <= pwdata;
				REG_QUARK_RANGE: quark_range_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GOAL_X:      prdata = goal_x_q;
			REG_GOAL_Y:      prdata = goal_y_q;
			REG_ATT_GAIN:    prdata = att_gain_q;
			REG_OBST_GAIN:   prdata = obst_gain_q;
			REG_OBST_RANGE:  prdata = {1'b0, obst_range_q};
			REG_QUARK_GAIN:  prdata = quark_gain_q;
			REG_QUARK_RANGE: prdata = {1'b0, quark_range_q};
			default:         prdata = '0;
		endcase
	end

	// helpers
	function automatic logic [31:0] mag32(input logic [31:0] v);
		mag32 = v[31] ? 32'(-v) : v;
	endfunction

	function automatic logic [32:0] sat_term(input logic neg, input logic [63:0] mag);
		logic [32:0] r;
		if (neg) begin
			if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
			else                     r = {1'b0, 32'(-mag[31:0])};
		end else begin
			if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
			else                     r = {1'b0, mag[31:0]};
		end
		return r;
	endfunction

	function automatic logic [32:0] clamp33(input logic [32:0] v);
		logic [32:0] r;
		if (v[32] != v[31]) r = {1'b1, v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
		else                r = {1'b0, v[31:0]};
		return r;
	endfunction

	// goal difference with clamp
	logic [32:0] dxc, dyc;
	assign dxc = clamp33({goal_x_q[31], goal_x_q} - {pos_x_q[31], pos_x_q});
	assign dyc = clamp33({goal_y_q[31], goal_y_q} - {pos_y_q[31], pos_y_q});

	// one multiplier per lane, operands chosen by state
	logic [31:0] gain_sel, mul_ax, mul_bx, mul_ay, mul_by;
	logic [63:0] mul_x, mul_y;
	always_comb begin
		gain_sel = (kind_q == REQ_BEGIN) ? att_gain_q :
		           (kind_q == REQ_OBST)  ? obst_gain_q : quark_gain_q;
		if (state_q == ST_SQ) begin
			mul_ax = mag32(dx_q);
			mul_bx = mag32(dx_q);
			mul_ay = mag32(dy_q);
			mul_by = mag32(dy_q);
		end else begin
			mul_ax = mag32(gain_sel);
			mul_ay = mag32(gain_sel);
			mul_bx = (kind_q == REQ_BEGIN) ? mag32(dx_q) : mag32(dir_x_q);
			mul_by = (kind_q == REQ_BEGIN) ? mag32(dy_q) : mag32(dir_y_q);
		end
	end
	assign mul_x = {32'd0, mul_ax} * {32'd0, mul_bx};
	assign mul_y = {32'd0, mul_ay} * {32'd0, mul_by};

	// square root step: two radicand bits per cycle
	logic [35:0] srem_sh, strial;
	logic        sge;
	assign srem_sh = {srem_q[33:0], sq_sh_q[63:62]};
	assign strial  = {2'b00, root_q, 2'b01};
	assign sge     = srem_sh >= strial;

	// range checks
	logic obst_hit, quark_hit;
	assign obst_hit  = !dist_q[31] && (dist_q != 32'd0) && (dist_q[30:0] < obst_range_q);
	assign quark_hit = !dist_q[31] && (dist_q[30:0] <= quark_range_q);

	// dividers, one per lane, sharing the divisor
	div_cmd_t    div_cmd;
	logic        div_done_x, div_done_y, div_done;
	logic [63:0] quot_x, quot_y;
	assign div_cmd.start = (state_q == ST_DIVGO);
	assign div_cmd.scale = !div_first_q;
	assign div_done      = div_done_x && div_done_y;

	pffs_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk(clk), .arst_n(arst_n), .cmd(div_cmd), .numer(val_x_q),
		.divisor(divisor_q), .done(div_done_x), .quot(quot_x)
	);
	pffs_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk(clk), .arst_n(arst_n), .cmd(div_cmd), .numer(val_y_q),
		.divisor(divisor_q), .done(div_done_y), .quot(quot_y)
	);

	// signed terms and sum update
	logic [32:0] tx, ty, nsx, nsy;
	assign tx  = sat_term(neg_x_q, val_x_q);
	assign ty  = sat_term(neg_y_q, val_y_q);
	assign nsx = clamp33({sum_x_q[31], sum_x_q} - {tx[31], tx[31:0]});
	assign nsy = clamp33({sum_y_q[31], sum_y_q} - {ty[31], ty[31:0]});

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// result valid: raise on emit, drop once the transfer is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && last_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sat_seen_q  <= 1'b0;
			div_left_q  <= '0;
			div_first_q <= 1'b0;
			scnt_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (req_type == REQ_BEGIN) state_q <= ST_DIFF;
						else if (req_type == REQ_OBST || req_type == REQ_QUARK)
							state_q <= ST_REP;
						else state_q <= ST_FIN;
					end
				end
				ST_DIFF:  state_q <= ST_SQ;
				ST_SQ:    state_q <= ST_SUM;
				ST_SUM: begin
					scnt_q  <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					scnt_q <= scnt_q + 5'd1;
					if (scnt_q == 5'd31) state_q <= ST_AMUL;
				end
				ST_AMUL: begin
					div_left_q  <= 2'd3;
					div_first_q <= 1'b1;
					state_q     <= (root_q > ONE_RAW) ? ST_DIVGO : ST_SHIFT;
				end
				ST_SHIFT: state_q <= ST_SIGN;
				ST_DIVGO: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_done) begin
						div_first_q <= 1'b0;
						div_left_q  <= div_left_q - 2'd1;
						state_q     <= (div_left_q == 2'd1) ? ST_SIGN : ST_DIVGO;
					end
				end
				ST_REP: begin
					if ((kind_q == REQ_OBST) ? obst_hit : quark_hit) state_q <= ST_RMUL;
					else state_q <= ST_FIN;
				end
				ST_RMUL: begin
					div_left_q  <= 2'd2;
					div_first_q <= 1'b1;
					state_q     <= (dist_q == 32'd0) ? ST_SIGN : ST_DIVGO;
				end
				ST_SIGN: begin
					if (kind_q == REQ_BEGIN) begin
						sum_x_q    <= tx[31:0];
						sum_y_q    <= ty[31:0];
						sat_seen_q <= sat_acc_q | tx[32] | ty[32];
					end else begin
						sum_x_q    <= nsx[31:0];
						sum_y_q    <= nsy[31:0];
						sat_seen_q <= sat_seen_q | tx[32] | ty[32] | nsx[32] | nsy[32];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q || out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					kind_q    <= req_type;
					pos_x_q   <= pos_x;
					pos_y_q   <= pos_y;
					dist_q    <= reading_dist;
					dir_x_q   <= dir_x;
					dir_y_q   <= dir_y;
					last_q    <= last;
					sat_acc_q <= 1'b0;
				end
			end
			ST_DIFF: begin
				dx_q      <= dxc[31:0];
				dy_q      <= dyc[31:0];
				sat_acc_q <= dxc[32] | dyc[32];
			end
			ST_SQ: begin
				val_x_q <= mul_x;
				val_y_q <= mul_y;
			end
			ST_SUM: begin
				sq_sh_q <= val_x_q + val_y_q;
				srem_q  <= '0;
				root_q  <= '0;
			end
			ST_SQRT: begin
				sq_sh_q <= {sq_sh_q[61:0], 2'b00};
				srem_q  <= sge ? (srem_sh - strial) : srem_sh;
				root_q  <= {root_q[30:0], sge};
			end
			ST_AMUL: begin
				val_x_q   <= mul_x;
				val_y_q   <= mul_y;
				neg_x_q   <= !(att_gain_q[31] ^ dx_q[31]);
				neg_y_q   <= !(att_gain_q[31] ^ dy_q[31]);
				divisor_q <= root_q;
			end
			ST_SHIFT: begin
				val_x_q <= val_x_q >> FRAC_BITS;
				val_y_q <= val_y_q >> FRAC_BITS;
			end
			ST_DIVW: begin
				if (div_done) begin
					val_x_q <= quot_x;
					val_y_q <= quot_y;
				end
			end
			ST_RMUL: begin
				neg_x_q   <= gain_sel[31] ^ dir_x_q[31];
				neg_y_q   <= gain_sel[31] ^ dir_y_q[31];
				divisor_q <= dist_q;
				if (dist_q == 32'd0) begin
					val_x_q <= (mul_x != 64'd0) ? MAG_HUGE : 64'd0;
					val_y_q <= (mul_y != 64'd0) ? MAG_HUGE : 64'd0;
				end else begin
					val_x_q <= mul_x;
					val_y_q <= mul_y;
				end
			end
			ST_FIN: begin
				if (last_q && out_free) begin
					force_x_q   <= sum_x_q;
					force_y_q   <= sum_y_q;
					saturated_q <= sat_seen_q;
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign force_x   = force_x_q;
	assign force_y   = force_y_q;
	assign saturated = saturated_q;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for potential_field_force_sum_core
// Drives begin, obstacle and quark transfers with random gaps and output
// stalls, predicts each emitted force sum in Q16.16 and checks it per field.
// ----------------------------------------------------------------------------
module tb_top;
	import pffs_pkg::*;

	localparam int          FRAC      = 16;
	localparam longint      LIMIT     = 5000000;
	localparam int          SETTLE    = 300;
	localparam logic [63:0] ONE_RAW   = 64'd1 << FRAC;
	localparam longint      POS_MAX   = 64'sd2147483647;
	localparam longint      NEG_MIN   = -64'sd2147483648;
	localparam logic [1:0]  REQ_SPARE = 2'd3;

	typedef struct packed {
		logic [31:0] fx;
		logic [31:0] fy;
		logic        sat;
	} force_t;

	logic              clk, arst_n;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata, prdata;
	logic              pready;
	logic              in_valid, in_stall;
	logic [1:0]        req_type;
	logic [31:0]       pos_x, pos_y, reading_dist, dir_x, dir_y;
	logic              last;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [31:0]       force_x, force_y;
	logic              saturated;

	// predicted block state and registers
	longint      goal_x, goal_y, att_gain, obst_gain, quark_gain;
	logic [63:0] obst_range, quark_range;
	longint      acc_x, acc_y;
	bit          acc_sat;

	force_t  pending_forces[$];
	int      mismatches;
	longint  cycles = 0;
	int      snd_idle_pct, rcv_idle_pct;

	potential_field_force_sum_core u_top (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// random output stall
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		force_t exp_f;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_forces.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%h y=%h sat=%b",
						force_x, force_y, saturated);
			end else begin
				exp_f = pending_forces.pop_front();
				if (exp_f.fx !== force_x || exp_f.fy !== force_y ||
					exp_f.sat !== saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp x=%h y=%h sat=%b got x=%h y=%h sat=%b",
							exp_f.fx, exp_f.fy, exp_f.sat, force_x, force_y, saturated);
				end
			end
		end
	end

	// ---------------- force predictor ----------------
	function automatic logic [63:0] magnitude(longint v);
		return (v < 0) ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic longint clamp_word(longint v, inout bit sat);
		if (v > POS_MAX) begin
			sat = 1'b1;
			return POS_MAX;
		end
		if (v < NEG_MIN) begin
			sat = 1'b1;
			return NEG_MIN;
		end
		return v;
	endfunction

	function automatic longint apply_sign(bit neg, logic [63:0] mag, inout bit sat);
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				sat = 1'b1;
				return NEG_MIN;
			end
			return -longint'(mag);
		end
		if (mag > 64'h7FFF_FFFF) begin
			sat = 1'b1;
			return POS_MAX;
		end
		return longint'(mag);
	endfunction

	// (m * 2^F) / d, overflow gives the huge mark
	function automatic logic [63:0] frac_div(logic [63:0] m, logic [63:0] d);
		if (m >= MAG_HUGE || (m >> (63 - FRAC)) != 0)
			return MAG_HUGE;
		return (m << FRAC) / d;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint attract(longint delta, logic [63:0] d, inout bit sat);
		logic [63:0] mag;
		bit          neg;
		mag = magnitude(att_gain) * magnitude(delta);
		neg = !((att_gain < 0) != (delta < 0));
		if (d > ONE_RAW) begin
			mag = mag / d;
			mag = frac_div(mag, d);
			mag = frac_div(mag, d);
		end else begin
			mag >>= FRAC;
		end
		return apply_sign(neg, mag, sat);
	endfunction

	function automatic longint repel(longint gain, longint dir, logic [63:0] d,
		inout bit sat);
		logic [63:0] mag;
		bit          neg;
		mag = magnitude(gain) * magnitude(dir);
		neg = (gain < 0) != (dir < 0);
		if (mag == 0)
			return 0;
		if (d == 0)
			return apply_sign(neg, MAG_HUGE, sat);
		mag = mag / d;
		mag = frac_div(mag, d);
		return apply_sign(neg, mag, sat);
	endfunction

	task automatic predict_force(logic [1:0] kind, logic [31:0] px, logic [31:0] py,
		logic [31:0] dist_w, logic [31:0] vx_w, logic [31:0] vy_w, logic lst);
		longint      rdist, vx, vy, dx, dy, gain, tx, ty;
		logic [63:0] d;
		bit          sat, hit;
		force_t      nf;
		rdist = longint'($signed(dist_w));
		vx = longint'($signed(vx_w));
		vy = longint'($signed(vy_w));
		sat = 1'b0;
		if (kind == REQ_BEGIN) begin
			dx = clamp_word(goal_x - longint'($signed(px)), sat);
			dy = clamp_word(goal_y - longint'($signed(py)), sat);
			d = int_sqrt(magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy));
			acc_x = attract(dx, d, sat);
			acc_y = attract(dy, d, sat);
			acc_sat = sat;
		end else if (kind == REQ_OBST || kind == REQ_QUARK) begin
			if (kind == REQ_OBST) begin
				hit = rdist > 0 && 64'(rdist) < obst_range;
				gain = obst_gain;
			end else begin
				hit = rdist >= 0 && 64'(rdist) <= quark_range;
				gain = quark_gain;
			end
			if (hit) begin
				tx = repel(gain, vx, 64'(rdist), sat);
				ty = repel(gain, vy, 64'(rdist), sat);
				acc_x = clamp_word(acc_x - tx, sat);
				acc_y = clamp_word(acc_y - ty, sat);
				if (sat)
					acc_sat = 1'b1;
			end
		end
		if (lst) begin
			nf.fx = acc_x[31:0];
			nf.fy = acc_y[31:0];
			nf.sat = acc_sat;
			pending_forces.insert(pending_forces.size(), nf);
		end
	endtask

	// ---------------- drivers ----------------
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = ADDR_W'(idx) << 2;
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_GOAL_X:      goal_x = longint'($signed(val));
			REG_GOAL_Y:      goal_y = longint'($signed(val));
			REG_ATT_GAIN:    att_gain = longint'($signed(val));
			REG_OBST_GAIN:   obst_gain = longint'($signed(val));
			REG_OBST_RANGE:  obst_range = 64'(val[30:0]);
			REG_QUARK_GAIN:  quark_gain = longint'($signed(val));
			REG_QUARK_RANGE: quark_range = 64'(val[30:0]);
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// hold until every result is in, then let the block settle
	task automatic drain();
		while (pending_forces.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic load_regs(logic [31:0] gx, logic [31:0] gy, logic [31:0] ag,
		logic [31:0] og, logic [31:0] orng, logic [31:0] qg, logic [31:0] qrng);
		drain();
		write_reg(REG_GOAL_X, gx);
		write_reg(REG_GOAL_Y, gy);
		write_reg(REG_ATT_GAIN, ag);
		write_reg(REG_OBST_GAIN, og);
		write_reg(REG_OBST_RANGE, orng);
		write_reg(REG_QUARK_GAIN, qg);
		write_reg(REG_QUARK_RANGE, qrng);
	endtask

	// present one transfer and hold it until accepted
	task automatic send_item(logic [1:0] kind, logic [31:0] px, logic [31:0] py,
		logic [31:0] rdist, logic [31:0] vx, logic [31:0] vy, logic lst);
		while ($urandom_range(99) < snd_idle_pct)
			@(negedge clk);
		req_type = kind;
		pos_x = px;
		pos_y = py;
		reading_dist = rdist;
		dir_x = vx;
		dir_y = vy;
		last = lst;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_force(kind, px, py, rdist, vx, vy, lst);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// ---------------- random values ----------------
	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(8 << FRAC)) - (4 << FRAC));
			2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			3: return 32'($signed($urandom_range(65535)) - 32768);
			default: return 32'($signed($urandom_range(400 << FRAC)) - (200 << FRAC));
		endcase
	endfunction

	function automatic logic [31:0] rand_dist(logic [63:0] rng);
		case ($urandom_range(9))
			0: return 32'h8000_0000 | $urandom;
			1: return 32'd0;
			2: return rng[31:0];
			3: return rng[31:0] + 1;
			4: return rng[31:0] - 1;
			5: return $urandom;
			6: return $urandom_range(ONE_RAW);
			default: return $urandom_range(rng[31:0]);
		endcase
	endfunction

	function automatic logic [31:0] rand_range();
		case ($urandom_range(3))
			0: return $urandom & 32'h7FFF_FFFF;
			1: return $urandom_range(4 << FRAC);
			default: return $urandom_range(64 << FRAC);
		endcase
	endfunction

	task automatic send_reading(logic lst);
		logic [1:0] kind;
		kind = $urandom_range(1) ? REQ_QUARK : REQ_OBST;
		send_item(kind, $urandom, $urandom,
			rand_dist(kind == REQ_OBST ? obst_range : quark_range),
			rand_word(), rand_word(), lst);
	endtask

	// well-formed begin/readings/last frames with some noise in between
	task automatic run_frames(int count);
		int sent, n;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) == 0) begin
				// stray transfer: spare kind, reading without begin, or early last
				if ($urandom_range(2) == 0)
					send_item(REQ_SPARE, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom_range(1));
				else
					send_reading($urandom_range(1));
				sent++;
			end else begin
				n = $urandom_range(4);
				send_item(REQ_BEGIN, rand_word(), rand_word(), $urandom, $urandom,
					$urandom, n == 0);
				for (int i = 1; i <= n; i++)
					send_reading(i == n || $urandom_range(7) == 0);
				sent += n + 1;
			end
		end
	endtask

	// ---------------- tests ----------------
	task automatic test_directed();
		// defaults: unit gains and ranges, goal at the origin
		send_item(REQ_BEGIN, 0, 0, 0, 0, 0, 1);
		send_item(REQ_BEGIN, 32'h0000_8000, 32'hFFFF_8000, 0, 0, 0, 1);
		send_item(REQ_BEGIN, 32'h0003_0000, 32'hFFFC_0000, 0, 0, 0, 1);
		send_item(REQ_BEGIN, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 1);
		send_item(REQ_BEGIN, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0);
		// quark at zero distance, zero product at zero distance
		send_item(REQ_QUARK, 0, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 1);
		send_item(REQ_QUARK, 0, 0, 0, 0, 0, 1);
		// obstacle at zero and at its range: no term
		send_item(REQ_OBST, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0);
		send_item(REQ_OBST, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1);
		// quark at its range, obstacle just inside
		send_item(REQ_BEGIN, 32'h0000_1000, 0, 0, 0, 0, 0);
		send_item(REQ_QUARK, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000, 0);
		send_item(REQ_OBST, 0, 0, 32'h0000_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1);
		// negative distance, tiny distance overflow, spare kind
		send_item(REQ_QUARK, 0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
		send_item(REQ_OBST, 0, 0, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1);
		send_item(REQ_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
		// extreme registers
		load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(REQ_BEGIN, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 1);
		send_item(REQ_BEGIN, 32'h7FFF_FFF0, 32'h8000_0010, 0, 0, 0, 0);
		send_item(REQ_OBST, 0, 0, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_item(REQ_QUARK, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1);
		load_regs(0, 0, 0, 0, 0, 0, 0);
		send_item(REQ_BEGIN, 32'h1234_5678, 32'h8765_4321, 0, 0, 0, 0);
		send_item(REQ_OBST, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0);
		send_item(REQ_QUARK, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 1);
	endtask

	task automatic test_random_phase(int count);
		load_regs(rand_word(), rand_word(), rand_word(), rand_word(), rand_range(),
			rand_word(), rand_range());
		run_frames(count / 2);
		load_regs(rand_word(), rand_word(), rand_word(), rand_word(), rand_range(),
			rand_word(), rand_range());
		run_frames(count - count / 2);
	endtask

	// hold off the sender until every result is back, then continue
	task automatic test_drained_restart();
		run_frames(20);
		while (pending_forces.size() != 0)
			@(negedge clk);
		run_frames(20);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		req_type = REQ_BEGIN;
		pos_x = '0;
		pos_y = '0;
		reading_dist = '0;
		dir_x = '0;
		dir_y = '0;
		last = 1'b0;
		mismatches = 0;
		goal_x = 0;
		goal_y = 0;
		att_gain = 65536;
		obst_gain = 65536;
		obst_range = 65536;
		quark_gain = 65536;
		quark_range = 65536;
		acc_x = 0;
		acc_y = 0;
		acc_sat = 1'b0;
		snd_idle_pct = 19;
		rcv_idle_pct = 73;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_phase(580);
		snd_idle_pct = 73;
		rcv_idle_pct = 19;
		test_drained_restart();
		test_random_phase(560);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random_phase(620);

		drain();
		if (mismatches == 0 && pending_forces.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: potential_field_force_sum_core.f
design/pffs_pkg.sv
design/pffs_div.sv
design/potential_field_force_sum_core.sv
dv/tb_top.sv
